// File: hdl/dfcf_pkg.sv
`default_nettype none

package dfcf_pkg;

    // Fields of one input transfer.
    typedef struct packed {
        logic [7:0] chan_value;
        logic [7:0] frame_len;
        logic       start_req;
    } t_in_item;

    // Fields of one output transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
    } t_out_item;

    localparam int MAX_CHANNELS_DEF = 32;

    // Longest burst of bytes one input item can cause: header plus trailer.
    localparam int BURST_MAX   = 7;
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

    localparam logic [7:0]  SYNC_A   = 8'h55;
    localparam logic [7:0]  SYNC_B   = 8'hF0;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // One byte of reflected CRC-32, bit at a time.
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC state after both sync bytes, which never change.
    localparam logic [31:0] CRC_AFTER_SYNC = crc_step(crc_step(CRC_INIT, SYNC_A), SYNC_B);

endpackage

`default_nettype wire

// File: hdl/dfcf_burst_buf.sv
`default_nettype none

// Holds the bytes caused by one item and hands them out one per transfer.
module dfcf_burst_buf
    import dfcf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [BURST_CNT_W-1:0] i_load_cnt,
    input  wire t_out_item              i_load_items [BURST_MAX],
    output logic                        o_room,
    output logic                        o_valid,
    output t_out_item                   o_data,
    input  wire logic                   i_stall
);

    logic [BURST_CNT_W-1:0] r_rem;
    logic [BURST_CNT_W-1:0] n_rem;
    t_out_item              r_buf [BURST_MAX];
    t_out_item              n_buf [BURST_MAX];
    logic                   xfer;

    assign o_valid = (r_rem != '0);
    assign o_data  = r_buf[0];
    assign xfer    = o_valid && !i_stall;
    // Room when empty, or when the last byte leaves in this cycle.
    assign o_room  = (r_rem == '0) || ((r_rem == BURST_CNT_W'(1)) && !i_stall);

    always_comb begin
        n_rem = r_rem;
        n_buf = r_buf;
        if (i_load) begin
            n_rem = i_load_cnt;
            n_buf = i_load_items;
        end else if (xfer) begin
            n_rem = r_rem - BURST_CNT_W'(1);
            for (int k = 0; k < BURST_MAX - 1; k++) begin
                n_buf[k] = r_buf[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

`default_nettype wire

// File: hdl/dimmer_frame_crc_framer_unit.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall   o_out_data (t_out_item)
//
// Each accepted item is processed in the cycle it is accepted: one byte of
// CRC-32 is folded in and all bytes the item causes are loaded into a burst
// buffer, which emits one byte per output transfer from the next cycle on.
// A channel value item causes one byte; a start item causes three bytes, and
// a value or start that closes its frame adds the four CRC bytes.
// The burst buffer sets the rate: a new item is accepted when the buffer is
// empty or its last byte is transferred in the same cycle, so o_in_stall
// follows i_out_stall combinationally. Synchronous reset empties the buffer
// and closes any open frame.

module dimmer_frame_crc_framer_unit
    import dfcf_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    localparam logic [7:0] MaxCh = 8'(MAX_CHANNELS);

    // Frame state.
    logic [31:0] r_crc;
    logic [7:0]  r_sent;
    logic [7:0]  r_target;
    logic        r_open;
    logic [31:0] n_crc;
    logic [7:0]  n_sent;
    logic [7:0]  n_target;
    logic        n_open;

    logic                   room;
    logic                   accept;
    logic [7:0]             len_sat;
    logic [31:0]            crc_in;
    logic [7:0]             crc_byte_in;
    logic [31:0]            crc_new;
    logic [31:0]            crc_fin;
    logic [7:0]             sent_inc;
    logic                   load;
    logic [BURST_CNT_W-1:0] load_cnt;
    t_out_item              items [BURST_MAX];

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    // The count is clamped to the configured maximum; the clamped value is
    // both sent as the count byte and used as the number of channels.
    assign len_sat = (i_in_data.frame_len > MaxCh) ? MaxCh : i_in_data.frame_len;

    // A single byte-wide CRC step serves both item kinds. The sync bytes are
    // constant, so a start item only needs to fold in the count byte.
    assign crc_in      = i_in_data.start_req ? CRC_AFTER_SYNC : r_crc;
    assign crc_byte_in = i_in_data.start_req ? len_sat : i_in_data.chan_value;
    assign crc_new     = crc_step(crc_in, crc_byte_in);
    assign crc_fin     = ~crc_new;
    assign sent_inc    = r_sent + 8'd1;

    always_comb begin
        n_crc    = r_crc;
        n_sent   = r_sent;
        n_target = r_target;
        n_open   = r_open;
        load     = 1'b0;
        load_cnt = '0;
        for (int k = 0; k < BURST_MAX; k++) begin
            items[k] = '0;
        end

        if (accept) begin
            if (i_in_data.start_req) begin
                // A start abandons any open frame and sends the header.
                load              = 1'b1;
                items[0].out_byte = SYNC_A;
                items[1].out_byte = SYNC_B;
                items[2].out_byte = len_sat;
                if (len_sat == 8'd0) begin
                    // Empty frame: header and trailer in one burst.
                    load_cnt = BURST_CNT_W'(7);
                    for (int k = 0; k < 4; k++) begin
                        items[3+k].out_byte = crc_fin[8*k +: 8];
                    end
                    items[6].run_last   = 1'b1;
                    items[6].frame_done = 1'b1;
                    n_crc    = CRC_INIT;
                    n_sent   = 8'd0;
                    n_target = 8'd0;
                    n_open   = 1'b0;
                end else begin
                    load_cnt          = BURST_CNT_W'(3);
                    items[2].run_last = 1'b1;
                    n_crc    = crc_new;
                    n_sent   = 8'd0;
                    n_target = len_sat;
                    n_open   = 1'b1;
                end
            end else if (r_open) begin
                load              = 1'b1;
                items[0].out_byte = i_in_data.chan_value;
                if (sent_inc >= r_target) begin
                    // Last channel: append the CRC, low byte first.
                    load_cnt = BURST_CNT_W'(5);
                    for (int k = 0; k < 4; k++) begin
                        items[1+k].out_byte = crc_fin[8*k +: 8];
                    end
                    items[4].run_last   = 1'b1;
                    items[4].frame_done = 1'b1;
                    n_crc    = CRC_INIT;
                    n_sent   = 8'd0;
                    n_target = 8'd0;
                    n_open   = 1'b0;
                end else begin
                    load_cnt          = BURST_CNT_W'(1);
                    items[0].run_last = 1'b1;
                    n_crc  = crc_new;
                    n_sent = sent_inc;
                end
            end
            // A value outside an open frame is taken and dropped.
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_sent   <= 8'd0;
            r_target <= 8'd0;
            r_open   <= 1'b0;
        end else begin
            r_crc    <= n_crc;
            r_sent   <= n_sent;
            r_target <= n_target;
            r_open   <= n_open;
        end
    end

    dfcf_burst_buf u_burst_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_load_cnt   (load_cnt),
        .i_load_items (items),
        .o_room       (room),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data),
        .i_stall      (i_out_stall)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dfcf_pkg::*;

    localparam int MAX_CH          = MAX_CHANNELS_DEF;
    localparam int ITEMS_PER_PHASE = 62;
    // No transfer on either channel for this many cycles means the block is hung.
    localparam int IDLE_LIMIT      = 1000;

    // One row of the directed stimulus. Each row carries the number of bytes the
    // item must cause, plus one byte of that burst that can be read off by eye:
    // a sync byte, the count byte or an echoed channel value.
    typedef struct packed {
        t_in_item   item;
        logic [3:0] n_results;
        logic [2:0] byte_idx;
        logic [7:0] byte_val;
    } t_dir_row;

    // Fields of the item are chan_value, frame_len and start_req, in that order.
    localparam t_dir_row DIR_ROWS [21] = '{
        // A channel value straight out of reset finds no open frame and is dropped.
        '{'{8'hAB, 8'h00, 1'b0}, 4'd0, 3'd0, 8'h00},
        // A zero count gives the header and the trailer in one burst.
        '{'{8'h00, 8'h00, 1'b1}, 4'd7, 3'd2, 8'h00},
        // The largest count saturates to the channel maximum.
        '{'{8'hFF, 8'hFF, 1'b1}, 4'd3, 3'd2, 8'h20},
        // Restarting while a frame is open drops the old frame without a trailer.
        '{'{8'h5A, 8'h01, 1'b1}, 4'd3, 3'd2, 8'h01},
        '{'{8'hFF, 8'h00, 1'b0}, 4'd5, 3'd0, 8'hFF},
        '{'{8'h00, 8'h00, 1'b0}, 4'd0, 3'd0, 8'h00},
        // Counts exactly at and just above the maximum.
        '{'{8'h00, 8'h20, 1'b1}, 4'd3, 3'd2, 8'h20},
        '{'{8'h00, 8'h21, 1'b1}, 4'd3, 3'd2, 8'h20},
        '{'{8'h00, 8'h02, 1'b1}, 4'd3, 3'd2, 8'h02},
        '{'{8'h00, 8'h00, 1'b0}, 4'd1, 3'd0, 8'h00},
        '{'{8'hFF, 8'h00, 1'b0}, 4'd5, 3'd0, 8'hFF},
        // The channel value of a start item and the count of a value item are ignored.
        '{'{8'hFF, 8'h03, 1'b1}, 4'd3, 3'd1, 8'hF0},
        '{'{8'h80, 8'hAA, 1'b0}, 4'd1, 3'd0, 8'h80},
        '{'{8'h01, 8'hFF, 1'b0}, 4'd1, 3'd0, 8'h01},
        '{'{8'h7F, 8'h00, 1'b0}, 4'd5, 3'd0, 8'h7F},
        '{'{8'h55, 8'h00, 1'b0}, 4'd0, 3'd0, 8'h00},
        '{'{8'h00, 8'h80, 1'b1}, 4'd3, 3'd0, 8'h55},
        // Abandoning a long frame for an empty one.
        '{'{8'h00, 8'h00, 1'b1}, 4'd7, 3'd1, 8'hF0},
        '{'{8'h00, 8'h01, 1'b1}, 4'd3, 3'd2, 8'h01},
        '{'{8'hAA, 8'h55, 1'b0}, 4'd5, 3'd0, 8'hAA},
        '{'{8'h00, 8'h00, 1'b0}, 4'd0, 3'd0, 8'h00}
    };

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Idle rates in percent of cycles, changed between the stimulus phases.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatch_cnt = 0;

    // Shadow of the framer's state, advanced once per accepted input transfer.
    logic [31:0] crc_run     = CRC_INIT;
    logic [7:0]  chan_sent   = '0;
    logic [7:0]  chan_target = '0;
    logic        frame_live  = 1'b0;

    // Bytes caused by the most recent input transfer, and every byte still owed.
    t_out_item burst_q[$];
    t_out_item frame_bytes_due[$];

    dimmer_frame_crc_framer_unit #(
        .MAX_CHANNELS (MAX_CH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A byte that enters the CRC (header or channel value) goes out unchanged.
    // The CRC is the reflected form, one bit per step, shifting toward bit 0.
    function automatic void emit_data(input logic [7:0] b);
        crc_run = crc_run ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            crc_run = (crc_run >> 1) ^ (CRC_POLY & {32{crc_run[0]}});
        end
        burst_q.push_back('{out_byte: b, run_last: 1'b0, frame_done: 1'b0});
    endfunction

    // The inverted CRC goes out low byte first; its last byte closes the frame
    // and everything returns to the idle values.
    function automatic void emit_trailer();
        logic [31:0] sum;
        sum = ~crc_run;
        for (int k = 0; k < 4; k++) begin
            burst_q.push_back('{out_byte: sum[8*k +: 8], run_last: 1'b0,
                                frame_done: (k == 3)});
        end
        crc_run     = CRC_INIT;
        chan_sent   = '0;
        chan_target = '0;
        frame_live  = 1'b0;
    endfunction

    // Works out the bytes one accepted item causes and queues them for checking.
    function automatic void predict_frame_bytes(input t_in_item it);
        logic [7:0] count;
        t_out_item  tail;
        burst_q.delete();
        if (it.start_req) begin
            // A start always begins from a fresh CRC, whatever was open before.
            count       = (it.frame_len > MAX_CH) ? 8'(MAX_CH) : it.frame_len;
            crc_run     = CRC_INIT;
            chan_sent   = '0;
            chan_target = count;
            frame_live  = 1'b1;
            emit_data(SYNC_A);
            emit_data(SYNC_B);
            emit_data(count);
            if (count == 8'd0) begin
                emit_trailer();
            end
        end else if (frame_live) begin
            emit_data(it.chan_value);
            chan_sent = chan_sent + 8'd1;
            if (chan_sent >= chan_target) begin
                emit_trailer();
            end
        end
        // The final byte of each burst is flagged so the receiver can tell
        // where one item's output ends.
        if (burst_q.size() != 0) begin
            tail = burst_q.pop_back();
            tail.run_last = 1'b1;
            burst_q.push_back(tail);
        end
        foreach (burst_q[i]) begin
            frame_bytes_due.push_back(burst_q[i]);
        end
    endfunction

    function automatic t_in_item rand_item(input logic start, input logic [7:0] len);
        t_in_item it;
        it.chan_value = 8'($urandom_range(0, 255));
        it.frame_len  = start ? len : 8'($urandom_range(0, 255));
        it.start_req  = start;
        return it;
    endfunction

    // Offers one item and returns at the edge where it is transferred. Valid
    // stays high between back-to-back items; it only drops for a sender gap.
    // Prediction happens at the transfer edge, well before the first byte of
    // the burst can appear in the next cycle.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_frame_bytes(it);
    endtask

    // Receiver: checks each output transfer against the oldest byte still owed,
    // then decides whether to stall the next cycle.
    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected output, expected none, got byte %02h last %b done %b",
                         $time, o_out_data.out_byte, o_out_data.run_last,
                         o_out_data.frame_done);
                mismatch_cnt++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, want.out_byte, o_out_data.out_byte);
                    mismatch_cnt++;
                end
                if (o_out_data.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b, got %b",
                             $time, want.run_last, o_out_data.run_last);
                    mismatch_cnt++;
                end
                if (o_out_data.frame_done !== want.frame_done) begin
                    $display("%0t: frame_done expected %b, got %b",
                             $time, want.frame_done, o_out_data.frame_done);
                    mismatch_cnt++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Watchdog: any transfer on either channel restarts the count of quiet cycles.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n);
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("dimmer_frame_crc_framer_unit: mismatch");
        $finish;
    end

    initial begin
        t_dir_row   row;
        t_in_item   it;
        logic [7:0] len;
        logic [7:0] got_byte;
        int         counted;
        int         n_vals;
        int         pick;

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed part. The receiver checks every byte against the prediction;
        // here the burst length and one byte per row are also held against the
        // values written into the table.
        tx_idle_pct = 17;
        rx_idle_pct = 45;
        for (int i = 0; i < $size(DIR_ROWS); i++) begin
            row = DIR_ROWS[i];
            send_item(row.item);
            if (burst_q.size() != int'(row.n_results) ||
                (row.n_results != 0 && burst_q[row.byte_idx].out_byte != row.byte_val)) begin
                got_byte = (burst_q.size() > int'(row.byte_idx)) ?
                           burst_q[row.byte_idx].out_byte : 8'h00;
                $display("%0t: row %0d expected %0d bytes, byte %0d = %02h; got %0d, %02h",
                         $time, i, row.n_results, row.byte_idx, row.byte_val,
                         burst_q.size(), got_byte);
                mismatch_cnt++;
            end
        end

        // Random part, in three phases of idling: sender light and receiver
        // heavy, then the reverse, then both sides at full rate. Most of the
        // stimulus is complete frames with random contents; some frames are cut
        // short by a new start, and a few stray values fall outside any frame.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 45 : 0;
            rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 17 : 0;
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 8) begin
                    // A stray value only counts when it lands inside a frame.
                    if (frame_live) begin
                        counted++;
                    end
                    send_item(rand_item(1'b0, 8'h00));
                end else begin
                    // Mostly short frames, some up to the maximum, and some
                    // counts that saturate and so give the longest frames.
                    pick = $urandom_range(0, 99);
                    if (pick < 65) begin
                        len = 8'($urandom_range(0, 6));
                    end else if (pick < 85) begin
                        len = 8'($urandom_range(7, MAX_CH));
                    end else begin
                        len = 8'($urandom_range(MAX_CH + 1, 255));
                    end
                    send_item(rand_item(1'b1, len));
                    counted++;
                    n_vals = (len > MAX_CH) ? MAX_CH : int'(len);
                    if (n_vals > 0 && $urandom_range(0, 99) < 12) begin
                        n_vals = $urandom_range(0, n_vals - 1);
                    end
                    repeat (n_vals) begin
                        send_item(rand_item(1'b0, 8'h00));
                        counted++;
                    end
                end
            end
        end
        in_valid <= 1'b0;

        // Drain what is still owed, then give the block a little longer in
        // case it sends bytes that nobody asked for.
        while (frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (BURST_MAX + 4) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("dimmer_frame_crc_framer_unit: match");
        end else begin
            $display("dimmer_frame_crc_framer_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/dfcf_pkg.sv
hdl/dfcf_burst_buf.sv
hdl/dimmer_frame_crc_framer_unit.sv
tb/sv/tb_top.sv
